// ===== hw/rtl/utfseg_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 code unit segmenter.
package utfseg_pkg;

  // Lead byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  localparam int unsigned WINDOW_BYTES = 4;
  localparam int unsigned TARGET_WIDTH = 16;

  // One accepted byte's worth of segmentation work: the byte window and the
  // units cut from it (offset and length of each, count of units).
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0][1:0] off;
    logic [3:0][2:0] len;
    logic [2:0]      count;
    logic            last;
  } job_t;

  // Expected unit length from the lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
    return len;
  endfunction

  // Byte mask for a unit of the given length
  function automatic logic [31:0] unit_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/utfseg_front.sv =====
// Front end: holds pending bytes, cuts each accepted beat into code units.
module utfseg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  input  logic             q_full,
  output logic             q_push,
  output utfseg_pkg::job_t q_job
);
  import utfseg_pkg::*;

  logic [2:0][7:0] pend;
  logic [1:0]      pend_count;
  logic [2:0][7:0] pend_next;
  logic [1:0]      pend_count_next;

  logic [3:0][7:0] win;
  logic [2:0]      total;
  logic [2:0]      pos;
  logic [2:0]      unit_cnt;
  logic            stop;
  logic [2:0]      len;
  logic [2:0]      ulen;
  logic [2:0]      avail;
  logic            ok;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Window: held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 2'(i) < pend_count) begin
        win[i] = pend[i];
      end else if (3'(i) == {1'b0, pend_count}) begin
        win[i] = text_byte;
      end else begin
        win[i] = 8'h00;
      end
    end
    total = {1'b0, pend_count} + 3'd1;
  end

  // Scan the window, at most four units per beat
  always_comb begin
    q_job       = '0;
    q_job.bytes = win;
    q_job.last  = end_of_text;
    pos         = 3'd0;
    unit_cnt    = 3'd0;
    stop        = 1'b0;
    len         = 3'd1;
    ulen        = 3'd1;
    avail       = 3'd0;
    ok          = 1'b1;
    for (int k = 0; k < 4; k++) begin
      len   = lead_length(win[pos[1:0]]);
      avail = total - pos;
      ulen  = 3'd1;
      ok    = 1'b1;
      if (!stop && pos < total) begin
        if (avail < len) begin
          // incomplete unit: wait for more bytes unless the text ends here
          if (!end_of_text) stop = 1'b1;
        end else begin
          for (int i = 1; i < 4; i++) begin
            if (3'(i) < len && (win[2'(pos + 3'(i))] & CONT_MASK) != CONT_CODE) ok = 1'b0;
          end
          ulen = ok ? len : 3'd1;
        end
        if (!stop) begin
          q_job.off[k] = pos[1:0];
          q_job.len[k] = ulen;
          pos          = pos + ulen;
          unit_cnt     = unit_cnt + 3'd1;
        end
      end
    end
    q_job.count = unit_cnt;
  end

  assign q_push = accept && (unit_cnt != 3'd0);

  // Leftover bytes after the scan
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (pos + 3'(j) < 3'd4) pend_next[j] = win[2'(pos + 3'(j))];
      else pend_next[j] = 8'h00;
    end
    pend_count_next = end_of_text ? 2'd0 : 2'(total - pos);
  end

  // Pending state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
    end else if (accept) begin
      pend_count <= pend_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

endmodule

// ===== hw/rtl/utfseg_queue.sv =====
// Short register queue of segmentation jobs between front and back end.
module utfseg_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utfseg_pkg::job_t push_job,
  input  logic             pop,
  output utfseg_pkg::job_t head_job,
  output logic             not_empty,
  output logic             full
);
  import utfseg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head_job  = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/utfseg_back.sv =====
// Back end: walks the units of each job, numbers them and drives the result register.
module utfseg_back #(
  parameter int ORDINAL_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  utfseg_pkg::job_t head_job,
  input  logic             head_valid,
  output logic             pop,
  input  logic [15:0]      target_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      unit_bytes,
  output logic [2:0]       unit_length,
  output logic [15:0]      unit_ordinal,
  output logic             index_match,
  output logic             final_unit
);
  import utfseg_pkg::*;

  logic [1:0]               uidx;
  logic [ORDINAL_WIDTH-1:0] ord;
  logic [31:0]              ord_ext;
  logic [31:0]              tgt_ext;
  logic                     load;
  logic                     last_of_job;
  logic [1:0]               cur_off;
  logic [2:0]               cur_len;
  logic [31:0]              cur_bytes;

  assign cur_off     = head_job.off[uidx];
  assign cur_len     = head_job.len[uidx];
  assign cur_bytes   = (head_job.bytes >> {cur_off, 3'b000}) & unit_mask(cur_len);
  assign last_of_job = ({1'b0, uidx} == head_job.count - 3'd1);
  assign load        = head_valid && (!out_valid || out_ready);
  assign pop         = load && last_of_job;
  assign ord_ext     = 32'(ord);
  assign tgt_ext     = 32'(target_index);

  // Unit walk, ordinal counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      uidx      <= 2'd0;
      ord       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      uidx      <= last_of_job ? 2'd0 : uidx + 2'd1;
      ord       <= (last_of_job && head_job.last) ? '0 : ord + ORDINAL_WIDTH'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      unit_bytes   <= cur_bytes;
      unit_length  <= cur_len;
      unit_ordinal <= ord_ext[15:0];
      index_match  <= (ord_ext == tgt_ext);
      final_unit   <= last_of_job && head_job.last;
    end
  end

endmodule

// ===== hw/rtl/utf8_codepoint_segmenter_core.sv =====
// UTF-8 code unit segmenter: front end, job queue, back end and target register.
// Throughput: one byte beat per cycle in while the job queue is not full, one code unit
// beat per cycle out while out_ready is high; the job queue absorbs a byte that
// closes several units, which leave the back end in turn. A closing beat's units
// pass through the job queue and then the result register before they are valid.
// Reset (synchronous, rst high) empties the queue and pending bytes, clears the
// ordinal counter and sets target_index to zero.
module utf8_codepoint_segmenter_core #(
  parameter int ORDINAL_WIDTH = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] unit_bytes,
  output logic [2:0]  unit_length,
  output logic [15:0] unit_ordinal,
  output logic        index_match,
  output logic        final_unit,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import utfseg_pkg::*;

  job_t        push_job;
  job_t        head_job;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  logic [15:0] target_index;

  // Target index register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_index <= 16'd0;
    end else if (cfg_we) begin
      target_index <= cfg_wdata;
    end
  end

  utfseg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  utfseg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  utfseg_back #(
    .ORDINAL_WIDTH (ORDINAL_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .head_valid   (q_not_empty),
    .pop          (q_pop),
    .target_index (target_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .unit_bytes   (unit_bytes),
    .unit_length  (unit_length),
    .unit_ordinal (unit_ordinal),
    .index_match  (index_match),
    .final_unit   (final_unit)
  );

  // Unit length is always one to four bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (unit_length != 3'd0 && unit_length <= 3'd4))
    else $error("unit_length out of range");

  // A single-byte unit carries no other bytes
  a_single_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unit_length == 3'd1) |-> (unit_bytes[31:8] == 24'd0))
    else $error("single-byte unit has stray bytes");

  // After the last unit of a text the next unit starts again at ordinal zero
  a_ordinal_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && final_unit) |=> (!out_valid || unit_ordinal == 16'd0))
    else $error("ordinal did not restart after final unit");

  // The queue never pops when empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("job queue popped while empty");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the UTF-8 code unit segmenter: directed table, then random texts.
module tb;
  import utfseg_pkg::*;

  localparam int LIMIT        = 800_000;
  localparam int RANDOM_BYTES = 170;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
    logic [15:0] ord;
    logic        hit;
    logic        last;
  } unit_t;

  typedef struct {
    logic [7:0] b;
    logic       eot;
    bit         typed;
    unit_t      want;
  } row_t;

  localparam unit_t NONE = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] unit_bytes;
  logic [2:0]  unit_length;
  logic [15:0] unit_ordinal;
  logic        index_match;
  logic        final_unit;

  // Predictor state: held bytes of an open unit, next ordinal, match target
  logic [7:0]  held [4];
  int          held_n = 0;
  logic [15:0] next_ord = 16'h0000;
  logic [15:0] target = 16'h0000;
  unit_t       units_due[$];
  unit_t       cut[$];

  int errors = 0;
  int cycles = 0;
  int random_sent = 0;
  int out_hold = 0;
  bit calm = 1'b0;

  utf8_codepoint_segmenter_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .unit_bytes   (unit_bytes),
    .unit_length  (unit_length),
    .unit_ordinal (unit_ordinal),
    .index_match  (index_match),
    .final_unit   (final_unit),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Unit length announced by a lead byte
  function automatic int lead_len(input logic [7:0] b);
    if ((b & LEAD2_MASK) == LEAD2_CODE) return 2;
    if ((b & LEAD3_MASK) == LEAD3_CODE) return 3;
    if ((b & LEAD4_MASK) == LEAD4_CODE) return 4;
    return 1;
  endfunction

  // Add one byte to the held window and cut every unit it closes into cut[]
  function automatic void cut_units(input logic [7:0] b, input logic eot);
    int    len;
    int    take;
    int    n;
    bit    stop;
    bit    ok;
    unit_t u;
    cut.delete();
    n = 0;
    stop = 1'b0;
    if (held_n < 4) begin
      held[held_n] = b;
      held_n++;
    end
    while (held_n > 0 && n < 4 && !stop) begin
      len = lead_len(held[0]);
      take = 1;
      if (held_n < len) begin
        // incomplete unit: wait for more, or flush the lead alone at end of text
        stop = !eot;
      end else begin
        ok = 1'b1;
        for (int i = 1; i < len; i++)
          if ((held[i] & CONT_MASK) != CONT_CODE) ok = 1'b0;
        if (ok) take = len;
      end
      if (!stop) begin
        u = '0;
        for (int i = 0; i < take; i++) u.bytes[8*i +: 8] = held[i];
        u.len = 3'(take);
        u.ord = next_ord;
        u.hit = (next_ord == target);
        cut.push_back(u);
        next_ord++;
        for (int i = 0; i < 4; i++) held[i] = (i + take < 4) ? held[i + take] : 8'h00;
        held_n -= take;
        n++;
      end
    end
    if (eot) begin
      if (cut.size() > 0) cut[cut.size() - 1].last = 1'b1;
      held_n = 0;
      next_ord = '0;
      for (int i = 0; i < 4; i++) held[i] = 8'h00;
    end
  endfunction

  // Idle length for either side: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one byte beat and queue the units it should produce
  task automatic send_beat(input logic [7:0] b, input logic eot, input bit typed,
                           input unit_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    cut_units(b, eot);
    if (typed) units_due.push_back(want);
    else foreach (cut[i]) units_due.push_back(cut[i]);
  endtask

  // Wait until every due unit is out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_target(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    target = v;
  endtask

  // One text: mostly well-formed units, some truncated sequences and raw noise
  task automatic send_text(input int units);
    logic [7:0] txt[$];
    int         r;
    int         len;
    int         keep;
    for (int u = 0; u < units; u++) begin
      r = $urandom_range(0, 99);
      len = 0;
      keep = 0;
      if (r < 80) begin
        len = $urandom_range(1, 4);
        keep = len;
      end else if (r < 92) begin
        len = $urandom_range(2, 4);
        keep = $urandom_range(1, len - 1);
      end
      case (len)
        0: txt.push_back(8'($urandom_range(0, 255)));
        1: txt.push_back({1'b0, 7'($urandom)});
        2: txt.push_back({3'b110, 5'($urandom)});
        3: txt.push_back({4'b1110, 4'($urandom)});
        default: txt.push_back({5'b11110, 3'($urandom)});
      endcase
      for (int i = 1; i < keep; i++) txt.push_back({2'b10, 6'($urandom)});
    end
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1, 1'b0, NONE);
    random_sent += txt.size();
  endtask

  // Sink side backpressure
  always @(posedge clk) begin : sink_stall
    int g;
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      g = idle_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        out_hold <= g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each unit beat with the oldest due unit
  always @(posedge clk) begin : check_units
    unit_t want;
    if (!rst && out_valid && out_ready) begin
      if (units_due.size() == 0) begin
        $error("code unit beat with no unit due: bytes %h", unit_bytes);
        errors++;
      end else begin
        want = units_due.pop_front();
        if (unit_bytes !== want.bytes) begin
          $error("unit_bytes: expected %h, got %h", want.bytes, unit_bytes);
          errors++;
        end
        if (unit_length !== want.len) begin
          $error("unit_length: expected %0d, got %0d", want.len, unit_length);
          errors++;
        end
        if (unit_ordinal !== want.ord) begin
          $error("unit_ordinal: expected %0d, got %0d", want.ord, unit_ordinal);
          errors++;
        end
        if (index_match !== want.hit) begin
          $error("index_match: expected %b, got %b", want.hit, index_match);
          errors++;
        end
        if (final_unit !== want.last) begin
          $error("final_unit: expected %b, got %b", want.last, final_unit);
          errors++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t plan[26];
    int   phase;
    // Directed text; target is zero from reset
    plan = '{
      '{8'h41, 1'b0, 1'b1, '{32'h41, 3'd1, 16'd0, 1'b1, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{32'h00, 3'd1, 16'd1, 1'b0, 1'b0}},
      '{8'h7F, 1'b0, 1'b1, '{32'h7F, 3'd1, 16'd2, 1'b0, 1'b0}},
      '{8'hC3, 1'b0, 1'b0, NONE},   // two-byte unit
      '{8'hA9, 1'b0, 1'b0, NONE},
      '{8'hE2, 1'b0, 1'b0, NONE},   // three-byte unit
      '{8'h82, 1'b0, 1'b0, NONE},
      '{8'hAC, 1'b0, 1'b0, NONE},
      '{8'hF0, 1'b0, 1'b0, NONE},   // four-byte unit
      '{8'h9F, 1'b0, 1'b0, NONE},
      '{8'h98, 1'b0, 1'b0, NONE},
      '{8'h80, 1'b0, 1'b0, NONE},
      '{8'hC3, 1'b0, 1'b0, NONE},   // broken two-byte sequence
      '{8'h41, 1'b0, 1'b0, NONE},
      '{8'hF8, 1'b0, 1'b0, NONE},   // not a lead
      '{8'h80, 1'b0, 1'b0, NONE},   // stray continuation
      '{8'hFF, 1'b0, 1'b0, NONE},
      '{8'hF4, 1'b0, 1'b0, NONE},   // broken at last byte: four units in one beat
      '{8'h80, 1'b0, 1'b0, NONE},
      '{8'h80, 1'b0, 1'b0, NONE},
      '{8'h41, 1'b0, 1'b0, NONE},
      '{8'hF0, 1'b0, 1'b0, NONE},   // text ends inside a unit
      '{8'h9F, 1'b0, 1'b0, NONE},
      '{8'h98, 1'b1, 1'b0, NONE},
      '{8'hFF, 1'b1, 1'b1, '{32'hFF, 3'd1, 16'd0, 1'b1, 1'b1}},
      '{8'h00, 1'b1, 1'b1, '{32'h00, 3'd1, 16'd0, 1'b1, 1'b1}}
    };
    for (int i = 0; i < 4; i++) held[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].b, plan[i].eot, plan[i].typed, plan[i].want);
    drain();

    // Random texts, new target per phase
    phase = 0;
    while (random_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      case (phase)
        0: write_target(16'hFFFF);
        1: write_target(16'h0000);
        default: begin
          if ($urandom_range(0, 3) != 0) write_target(16'($urandom_range(0, 8)));
          else write_target(16'($urandom_range(0, 65535)));
        end
      endcase
      repeat ($urandom_range(2, 4)) send_text($urandom_range(1, 10));
      drain();
      phase++;
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
